// File: design/grid_word_occurrence_counter_defines.svh
// Assertion macros for the grid word occurrence counter.
// Included by every file that carries concurrent assertions; no dependencies.
`ifndef GRID_WORD_OCCURRENCE_COUNTER_DEFINES_SVH
`define GRID_WORD_OCCURRENCE_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS
`define GWOC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gwoc assertion failed");
`define GWOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gwoc assertion failed");
`else
`define GWOC_ASSERT(label, clk, rst, prop)
`define GWOC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: design/gwoc_pkg.sv
// Shared types, constants and the window compare for the grid word occurrence counter.
// No dependencies; used by the interface instances, the line buffer and the top level.
package gwoc_pkg;

   localparam int SLOTS          = 3;
   localparam int HEAD_COLS      = 4;
   localparam int TAPS           = 7;
   localparam int WIN_LEN        = TAPS - 1;
   localparam int TAP_CUR        = 3;
   localparam int ROW_WIDTH_BITS = 11;
   localparam int WORD_BITS      = 32;
   localparam int CSR_IDX_BITS   = 2;

   localparam logic [CSR_IDX_BITS-1:0]   CSR_ROW_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0]   CSR_SEARCH_WORD   = 2'd1;
   localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET   = 11'd1024;
   localparam logic [WORD_BITS-1:0]      SEARCH_WORD_RESET = 32'h584D_4153;
   localparam logic [1:0]                ROWS_FULL         = 2'd3;

   typedef logic [7:0] byte_type;
   typedef byte_type [TAPS-1:0] tap_row_type;
   typedef tap_row_type [SLOTS-1:0] tap_set_type;
   typedef byte_type [SLOTS-1:0] slot_bytes_type;
   typedef byte_type [HEAD_COLS-1:0] head_row_type;
   typedef byte_type [WIN_LEN-1:0] win_row_type;

   typedef struct packed {
      logic     [7:0] grid_char;
      logic           grid_end;
   } req_word_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] match_count;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_IDX_BITS-1:0] index;
      logic [WORD_BITS-1:0]    data;
   } csr_word_type;

   typedef struct packed {
      logic       advance;
      logic       restart;
      logic [1:0] slot;
      byte_type   data;
   } lb_cmd_type;

   function automatic logic [1:0] word_hits(byte_type a, byte_type b, byte_type c,
                                            byte_type d, logic [WORD_BITS-1:0] word);
      logic [WORD_BITS-1:0] fwd;
      logic [WORD_BITS-1:0] rev;
      fwd = {a, b, c, d};
      rev = {d, c, b, a};
      return 2'(fwd == word) + 2'(rev == word);
   endfunction

endpackage

// File: design/gwoc_stream_if.sv
// Valid/ready channel carrying one payload word, with source and sink modports.
// Payload type is set per instance from gwoc_pkg word types.
interface gwoc_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// File: design/gwoc_line_buf.sv
// Line buffer: three rows of history in one byte-lane memory, head-column copies,
// and per-row tap windows around the current column. Depends on gwoc_pkg.
`include "grid_word_occurrence_counter_defines.svh"
module gwoc_line_buf
   import gwoc_pkg::*;
#(
   parameter int  MAX_ROW_WIDTH = 1024,
   localparam int AW            = $clog2(MAX_ROW_WIDTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  lb_cmd_type    cmd,
   input  logic [AW-1:0] col,
   output tap_set_type   taps
);

   localparam int RW = $clog2(MAX_ROW_WIDTH + HEAD_COLS);

   slot_bytes_type                 hist_mem [MAX_ROW_WIDTH];
   slot_bytes_type                 rd_ff;
   logic                           byp_v_ff;
   logic [1:0]                     byp_slot_ff;
   byte_type                       byp_data_ff;
   logic                           use_head_ff;
   slot_bytes_type                 lk3_ff;
   slot_bytes_type                 look;
   head_row_type [SLOTS-1:0]       head_ff;
   head_row_type [SLOTS-1:0]       head_in;
   win_row_type  [SLOTS-1:0]       win_ff;
   win_row_type  [SLOTS-1:0]       win_in;
   logic [RW-1:0]                  rd_wide;
   logic                           rd_en;
   logic [AW-1:0]                  rd_addr;
   logic                           hazard;

   assign rd_wide = RW'(col) + RW'(HEAD_COLS);
   assign rd_en   = cmd.advance && (rd_wide < RW'(MAX_ROW_WIDTH));
   assign rd_addr = rd_wide[AW-1:0];
   assign hazard  = rd_en && (rd_addr == col);

   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         hist_mem[col][cmd.slot] <= cmd.data;
      end
      if (rd_en) begin
         rd_ff <= hist_mem[rd_addr];
      end
   end

   always_comb begin
      for (int p = 0; p < SLOTS; p++) begin
         if (use_head_ff) begin
            look[p] = lk3_ff[p];
         end else if (byp_v_ff && (byp_slot_ff == 2'(p))) begin
            look[p] = byp_data_ff;
         end else begin
            look[p] = rd_ff[p];
         end
      end
   end

   always_comb begin
      head_in = head_ff;
      if (cmd.advance && ({1'b0, col} < (AW + 1)'(HEAD_COLS))) begin
         head_in[cmd.slot][col[$clog2(HEAD_COLS)-1:0]] = cmd.data;
      end
   end

   always_comb begin
      for (int p = 0; p < SLOTS; p++) begin
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            win_in[p][i] = win_ff[p][i + 1];
         end
         win_in[p][WIN_LEN-1] = look[p];
         if (cmd.restart) begin
            for (int i = 0; i < HEAD_COLS - 1; i++) begin
               win_in[p][TAP_CUR + i] = head_in[p][i];
            end
         end
      end
   end

   always_comb begin
      for (int p = 0; p < SLOTS; p++) begin
         for (int i = 0; i < WIN_LEN; i++) begin
            taps[p][i] = win_ff[p][i];
         end
         taps[p][TAPS-1] = look[p];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_v_ff    <= 1'b0;
         use_head_ff <= 1'b1;
      end else if (cmd.advance) begin
         byp_v_ff    <= hazard;
         use_head_ff <= cmd.restart;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         byp_slot_ff <= cmd.slot;
         byp_data_ff <= cmd.data;
         head_ff     <= head_in;
         win_ff      <= win_in;
         if (cmd.restart) begin
            for (int p = 0; p < SLOTS; p++) begin
               lk3_ff[p] <= head_in[p][HEAD_COLS-1];
            end
         end
      end
   end

   `GWOC_ASSERT(a_hazard_only_on_restart, clock, reset, hazard |-> cmd.restart)
   `GWOC_ASSERT(a_hazard_only_at_head_end, clock, reset,
                hazard |-> ({1'b0, col} == (AW + 1)'(HEAD_COLS)))
   `GWOC_ASSERT(a_bypass_under_head, clock, reset, byp_v_ff |-> use_head_ff)

endmodule

// File: design/grid_word_occurrence_counter.sv
// Grid word occurrence counter: takes a character grid in raster order on req_bus,
// one word per cycle, and counts a four-letter word in all eight directions.
// Configuration on csr_bus: index 0 is the row width, index 1 the search word
// (first letter in the top byte). Writes are taken at any time, csr_bus.ready is
// tied high; write them only while no grid word is in flight.
// Throughput: one grid word per cycle while req_bus.ready is high, set by the
// single read port of the line buffer memory, which fetches one column four
// places ahead of the current one. The total for a grid is registered into the
// output buffer as the word with grid_end set is taken; other words give no result.
// The output has a two-word buffer; req_bus.ready drops only while both hold
// totals that rsp_bus has not taken, so a stalled receiver stops the input then.
// Reset clears position, row count and total, sets the configuration to its reset
// values and leaves the line buffer memory (MAX_ROW_WIDTH words of three bytes)
// uncleared; it needs no pass. The total saturates at all ones.
`include "grid_word_occurrence_counter_defines.svh"
module grid_word_occurrence_counter
   import gwoc_pkg::*;
#(
   parameter int MAX_ROW_WIDTH = 1024
) (
   input  logic          clock,
   input  logic          reset,
   gwoc_stream_if.sink   req_bus,
   gwoc_stream_if.source rsp_bus,
   gwoc_stream_if.sink   csr_bus
);

   localparam int AW = $clog2(MAX_ROW_WIDTH);
   localparam int NW = (AW + 2 > 12) ? AW + 2 : 12;

   logic [ROW_WIDTH_BITS-1:0] row_width_ff;
   logic [WORD_BITS-1:0]      word_ff;
   logic [AW-1:0]             col_ff, col_in;
   logic [1:0]                rows_ff, rows_in;
   logic [1:0]                slot_ff, slot_in;
   logic [23:0]               recent_ff, recent_in;
   logic [WORD_BITS-1:0]      total_ff, total_in;
   rsp_word_type              out_ff, skid_ff;
   logic                      out_v_ff, skid_v_ff;

   logic                      req_acc, rsp_pop, push;
   byte_type                  ch;
   logic [NW-1:0]             col_ext, w_raw, w_eff;
   logic                      wrap, col_ge3, anti_ok, rows_full;
   logic [1:0]                s1, s2;
   tap_set_type               taps;
   tap_row_type               t_a, t_b, t_c;
   logic [1:0]                h_row, h_ver, h_dia, h_anti;
   logic [3:0]                hit_sum;
   logic [WORD_BITS:0]        tot_wide;
   lb_cmd_type                lb_cmd;

   assign req_acc         = req_bus.valid && req_bus.ready;
   assign rsp_pop         = rsp_bus.valid && rsp_bus.ready;
   assign push            = req_acc && req_bus.payload.grid_end;
   assign ch              = req_bus.payload.grid_char;
   assign req_bus.ready   = !skid_v_ff;
   assign csr_bus.ready   = 1'b1;
   assign rsp_bus.valid   = out_v_ff;
   assign rsp_bus.payload = out_ff;

   always_comb begin
      w_raw = NW'(row_width_ff);
      if (w_raw == '0) begin
         w_eff = NW'(1);
      end else if (w_raw > NW'(MAX_ROW_WIDTH)) begin
         w_eff = NW'(MAX_ROW_WIDTH);
      end else begin
         w_eff = w_raw;
      end
   end

   assign col_ext   = NW'(col_ff);
   assign wrap      = (col_ext + NW'(1)) >= w_eff;
   assign col_ge3   = col_ext >= NW'(3);
   assign anti_ok   = (col_ext + NW'(3)) < w_eff;
   assign rows_full = rows_ff == ROWS_FULL;

   always_comb begin
      case (slot_ff)
         2'd1: begin
            s2 = 2'd2;
            s1 = 2'd0;
         end
         2'd2: begin
            s2 = 2'd0;
            s1 = 2'd1;
         end
         default: begin
            s2 = 2'd1;
            s1 = 2'd2;
         end
      endcase
   end

   assign lb_cmd = '{advance: req_acc, restart: wrap || req_bus.payload.grid_end,
                     slot: slot_ff, data: ch};

   gwoc_line_buf #(.MAX_ROW_WIDTH(MAX_ROW_WIDTH)) u_line_buf (
      .clock (clock),
      .reset (reset),
      .cmd   (lb_cmd),
      .col   (col_ff),
      .taps  (taps)
   );

   assign t_c = (slot_ff == 2'd3) ? taps[0] : taps[slot_ff];
   assign t_b = taps[s2];
   assign t_a = taps[s1];

   always_comb begin
      h_row  = col_ge3 ? word_hits(recent_ff[23:16], recent_ff[15:8], recent_ff[7:0],
                                   ch, word_ff) : 2'd0;
      h_ver  = rows_full ? word_hits(t_c[TAP_CUR], t_b[TAP_CUR], t_a[TAP_CUR],
                                     ch, word_ff) : 2'd0;
      h_dia  = (rows_full && col_ge3) ?
               word_hits(t_c[TAP_CUR-3], t_b[TAP_CUR-2], t_a[TAP_CUR-1], ch, word_ff) : 2'd0;
      h_anti = (rows_full && anti_ok) ?
               word_hits(t_c[TAP_CUR+3], t_b[TAP_CUR+2], t_a[TAP_CUR+1], ch, word_ff) : 2'd0;
      hit_sum  = 4'(h_row) + 4'(h_ver) + 4'(h_dia) + 4'(h_anti);
      tot_wide = {1'b0, total_ff} + (WORD_BITS + 1)'(hit_sum);
   end

   always_comb begin
      total_in = tot_wide[WORD_BITS] ? '1 : tot_wide[WORD_BITS-1:0];
      if (wrap) begin
         col_in    = '0;
         rows_in   = rows_full ? rows_ff : rows_ff + 2'd1;
         slot_in   = s2;
         recent_in = '0;
      end else begin
         col_in    = col_ff + 1'b1;
         rows_in   = rows_ff;
         slot_in   = slot_ff;
         recent_in = {recent_ff[15:0], ch};
      end
      if (req_bus.payload.grid_end) begin
         col_in    = '0;
         rows_in   = '0;
         slot_in   = '0;
         recent_in = '0;
         total_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         word_ff      <= SEARCH_WORD_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.payload.index)
            CSR_ROW_WIDTH:   row_width_ff <= csr_bus.payload.data[ROW_WIDTH_BITS-1:0];
            CSR_SEARCH_WORD: word_ff      <= csr_bus.payload.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         rows_ff   <= '0;
         slot_ff   <= '0;
         recent_ff <= '0;
         total_ff  <= '0;
      end else if (req_acc) begin
         col_ff    <= col_in;
         rows_ff   <= rows_in;
         slot_ff   <= slot_in;
         recent_ff <= recent_in;
         total_ff  <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (!out_v_ff) begin
            out_v_ff <= push;
         end else if (rsp_pop) begin
            if (skid_v_ff) begin
               skid_v_ff <= 1'b0;
            end else begin
               out_v_ff <= push;
            end
         end else if (push) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || (rsp_pop && !skid_v_ff)) begin
         if (push) begin
            out_ff.match_count <= tot_wide[WORD_BITS] ? '1 : tot_wide[WORD_BITS-1:0];
         end
      end else if (rsp_pop) begin
         out_ff <= skid_ff;
      end
      if (out_v_ff && !rsp_pop && push) begin
         skid_ff.match_count <= tot_wide[WORD_BITS] ? '1 : tot_wide[WORD_BITS-1:0];
      end
   end

   `GWOC_ASSERT(a_skid_behind_out, clock, reset, skid_v_ff |-> out_v_ff)
   `GWOC_ASSERT(a_col_in_range, clock, reset, col_ext < NW'(MAX_ROW_WIDTH))
   `GWOC_ASSERT_NEXT(a_total_holds_or_grows, clock, reset,
                     req_acc && !req_bus.payload.grid_end, total_ff >= $past(total_ff))

endmodule

// File: tb/grid_word_occurrence_counter_tb.sv
// Testbench for grid_word_occurrence_counter: streams character grids and checks
// each reported total against a predictor that runs beside the block.
// Depends on gwoc_pkg, gwoc_stream_if and the block itself.
module grid_word_occurrence_counter_tb;
   import gwoc_pkg::*;

   localparam int MAX_COLS     = 1024;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 200;

   logic clock;
   logic reset;

   gwoc_stream_if #(.payload_type(req_word_type)) req_bus ();
   gwoc_stream_if #(.payload_type(rsp_word_type)) rsp_bus ();
   gwoc_stream_if #(.payload_type(csr_word_type)) csr_bus ();

   grid_word_occurrence_counter #(.MAX_ROW_WIDTH(MAX_COLS)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   byte_type                  line_history [SLOTS][MAX_COLS];
   int unsigned               col_pos;
   int unsigned               rows_done;
   int unsigned               row_slot;
   logic [23:0]               recent_chars;
   logic [23:0]               displaced_chars;
   logic [WORD_BITS-1:0]      grid_total;
   logic [ROW_WIDTH_BITS-1:0] cfg_row_width;
   logic [WORD_BITS-1:0]      cfg_word;
   logic [WORD_BITS-1:0]      expected_totals [$];
   logic [WORD_BITS-1:0]      awaited_total;

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned items_sent     = 0;
   int unsigned gap_max        = 2;
   int unsigned stall_pct      = 30;
   int unsigned burst_left     = 0;
   int unsigned hold_request   = 0;
   int unsigned hold_left      = 0;
   int unsigned stall_run      = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int unsigned eff_width();
      if (cfg_row_width == 0) return 1;
      if (cfg_row_width > MAX_COLS) return MAX_COLS;
      return cfg_row_width;
   endfunction

   function automatic void tally_window(byte_type a, byte_type b, byte_type c, byte_type d);
      int unsigned hits;
      hits = 0;
      if ({a, b, c, d} == cfg_word) hits++;
      if ({d, c, b, a} == cfg_word) hits++;
      repeat (hits) if (grid_total != '1) grid_total++;
   endfunction

   function automatic void restart_grid();
      col_pos         = 0;
      rows_done       = 0;
      row_slot        = 0;
      recent_chars    = '0;
      displaced_chars = '0;
      grid_total      = '0;
   endfunction

   function automatic void scan_grid_char(byte_type ch, logic last);
      int unsigned w;
      int unsigned col;
      int unsigned s1;
      int unsigned s2;
      int unsigned s3;
      w   = eff_width();
      col = col_pos;
      s1  = (row_slot + 2) % 3;
      s2  = (row_slot + 1) % 3;
      s3  = row_slot;
      if (col >= 3) tally_window(recent_chars[23:16], recent_chars[15:8], recent_chars[7:0], ch);
      if (rows_done >= 3) begin
         tally_window(line_history[s3][col], line_history[s2][col], line_history[s1][col], ch);
         if (col >= 3)
            tally_window(displaced_chars[23:16], line_history[s2][col-2],
                         line_history[s1][col-1], ch);
         if (col + 3 < w)
            tally_window(line_history[s3][col+3], line_history[s2][col+2],
                         line_history[s1][col+1], ch);
      end
      displaced_chars        = {displaced_chars[15:0], line_history[s3][col]};
      line_history[s3][col]  = ch;
      recent_chars           = {recent_chars[15:0], ch};
      if (col + 1 >= w) begin
         col_pos = 0;
         if (rows_done < 3) rows_done++;
         row_slot        = (row_slot + 1) % 3;
         recent_chars    = '0;
         displaced_chars = '0;
      end else begin
         col_pos = col + 1;
      end
      if (last) begin
         expected_totals = {expected_totals, grid_total};
         restart_grid();
      end
   endfunction

   function automatic byte_type pick_char();
      if ($urandom_range(0, 99) < 80) return cfg_word[8*$urandom_range(0, 3) +: 8];
      return 8'($urandom());
   endfunction

   function automatic logic [WORD_BITS-1:0] pick_word();
      byte_type a;
      byte_type b;
      a = 8'($urandom_range(65, 70));
      b = 8'($urandom_range(65, 70));
      case ($urandom_range(0, 3))
         0: return "XMAS";
         1: return {a, b, b, a};
         2: return {a, b, 8'($urandom_range(65, 70)), 8'($urandom_range(65, 70))};
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [WORD_BITS-1:0] pick_width();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return 0;
      if (roll < 10) return $urandom_range(MAX_COLS + 1, 2047);
      if (roll < 14) return MAX_COLS;
      return $urandom_range(1, 12);
   endfunction

   function automatic int unsigned grid_length();
      int unsigned w;
      int unsigned len;
      w = eff_width();
      if (w > 64) return $urandom_range(1, 40);
      len = $urandom_range(1, 8) * w;
      if ($urandom_range(0, 99) < 15) len = $urandom_range(1, len);
      return len;
   endfunction

   // receiver: long hold when asked, otherwise random stall runs
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_run > 0) begin
            stall_run--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_run = $urandom_range(0, 5);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_totals.size() == 0) begin
            mismatch_count++;
            $display("%0t: match_count expected none, actual %0d", $time,
                     rsp_bus.payload.match_count);
         end else begin
            awaited_total = expected_totals.pop_front();
            if (rsp_bus.payload.match_count !== awaited_total) begin
               mismatch_count++;
               $display("%0t: match_count expected %0d, actual %0d", $time, awaited_total,
                        rsp_bus.payload.match_count);
            end
         end
      end
   end

   task automatic send_grid_char(input byte_type ch, input logic last);
      int unsigned gaps;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gaps       = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         repeat (gaps) begin
            req_bus.valid <= 1'b0;
            @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid   <= 1'b1;
      req_bus.payload <= '{grid_char: ch, grid_end: last};
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      scan_grid_char(ch, last);
   endtask

   task automatic send_text(input string text, input logic ends_grid);
      for (int i = 0; i < text.len(); i++)
         send_grid_char(text[i], ends_grid && (i == text.len() - 1));
   endtask

   task automatic send_random_grid(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) send_grid_char(pick_char(), i == len - 1);
   endtask

   // drop valid and wait out every pending total
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_totals.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] reg_index,
                            input logic [WORD_BITS-1:0] reg_data);
      @(negedge clock);
      csr_bus.valid   <= 1'b1;
      csr_bus.payload <= '{index: reg_index, data: reg_data};
      do @(posedge clock); while (!csr_bus.ready);
      if (reg_index == CSR_ROW_WIDTH) cfg_row_width = reg_data[ROW_WIDTH_BITS-1:0];
      else if (reg_index == CSR_SEARCH_WORD) cfg_word = reg_data;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic test_reset_values();
      send_text("XMASAMX", 1'b1);
   endtask

   task automatic test_field_extremes();
      settle();
      csr_write(CSR_ROW_WIDTH, 2047);
      csr_write(CSR_SEARCH_WORD, 32'hFF00_00FF);
      send_grid_char(8'hFF, 1'b0);
      send_grid_char(8'h00, 1'b0);
      send_grid_char(8'h00, 1'b0);
      send_grid_char(8'hFF, 1'b1);
      settle();
      csr_write(CSR_ROW_WIDTH, 0);
      csr_write(CSR_SEARCH_WORD, "ABBA");
      send_text("ABBA", 1'b1);
   endtask

   task automatic test_directions();
      settle();
      csr_write(CSR_ROW_WIDTH, 4);
      csr_write(CSR_SEARCH_WORD, "XMAS");
      send_text("XMASMMAAAAAMSAAS", 1'b1);
   endtask

   task automatic test_full_width_grid();
      settle();
      gap_max   = 0;
      stall_pct = 0;
      csr_write(CSR_ROW_WIDTH, MAX_COLS);
      send_random_grid(MAX_COLS + 4);
   endtask

   task automatic test_width_change_mid_grid();
      int unsigned w1;
      int unsigned len;
      gap_max   = 3;
      stall_pct = 30;
      // fill all three rows over the columns that wider rows reach below
      settle();
      csr_write(CSR_ROW_WIDTH, 16);
      send_random_grid(48);
      repeat (4) begin
         settle();
         csr_write(CSR_ROW_WIDTH, $urandom_range(1, 10));
         w1  = eff_width();
         len = $urandom_range(3, 6) * w1 + $urandom_range(0, w1 - 1);
         for (int unsigned i = 0; i < len; i++) send_grid_char(pick_char(), 1'b0);
         settle();
         csr_write(CSR_ROW_WIDTH, $urandom_range(0, 14));
         if ($urandom_range(0, 1) == 1) csr_write(CSR_SEARCH_WORD, pick_word());
         send_random_grid($urandom_range(1, 30));
      end
   endtask

   task automatic test_output_backpressure();
      settle();
      gap_max   = 0;
      stall_pct = 0;
      csr_write(CSR_ROW_WIDTH, 4);
      csr_write(CSR_SEARCH_WORD, "XMAS");
      hold_request = 300;
      repeat (30) send_text("XMAS", 1'b1);
   endtask

   task automatic test_random_grids();
      int unsigned first;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         settle();
         case ($urandom_range(0, 2))
            0: gap_max = 0;
            1: gap_max = 2;
            default: gap_max = 8;
         endcase
         case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 30;
            default: stall_pct = 70;
         endcase
         if ($urandom_range(0, 2) != 0) csr_write(CSR_ROW_WIDTH, pick_width());
         if ($urandom_range(0, 2) != 0) csr_write(CSR_SEARCH_WORD, pick_word());
         repeat ($urandom_range(1, 2)) send_random_grid(grid_length());
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.payload = '0;
      cfg_row_width   = ROW_WIDTH_RESET;
      cfg_word        = SEARCH_WORD_RESET;
      restart_grid();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_field_extremes();
      test_directions();
      test_full_width_grid();
      test_width_change_mid_grid();
      test_output_backpressure();
      test_random_grids();

      settle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
